>>> hw/rtl/phs_pkg.sv
package phs_pkg;

    localparam int PHS_BUCKETS = 1024;
    localparam int PHS_NODES   = 4096;
    localparam int PHS_COORD_W = 16;
    localparam int PHS_GRID_W  = 16;
    localparam int PHS_KEY_W   = 32;
    localparam int PHS_Q_DEPTH = 2;

    localparam logic [PHS_GRID_W-1:0] PHS_GRID_RESET = 16'd1000;
    localparam logic [PHS_GRID_W-1:0] PHS_SUM_LIMIT  = 16'd40000;

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    typedef enum logic [2:0] {
        FR_IDLE,
        FR_HASH,
        FR_DIV,
        FR_REM,
        FR_PUSH
    } t_front_state;

    typedef enum logic [2:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_HEAD,
        BK_NODE,
        BK_FINISH
    } t_back_state;

endpackage

>>> hw/rtl/phs_front.sv
module phs_front import phs_pkg::*; #(
    parameter int BUCKETS = PHS_BUCKETS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_sum_hash,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_opcode,
    input  logic [PHS_COORD_W-1:0]              i_coord_x,
    input  logic [PHS_COORD_W-1:0]              i_coord_y,
    output logic                                o_push,
    output logic [2*PHS_COORD_W+$clog2(BUCKETS):0] o_job,
    input  logic                                i_full
);

    localparam int BW    = $clog2(BUCKETS);
    localparam logic [BW:0]          BUCKETS_C = (BW+1)'(BUCKETS);
    localparam logic [PHS_KEY_W-1:0] RECIP     =
        PHS_KEY_W'((64'd1 << PHS_KEY_W) / BUCKETS);

    t_front_state r_state, n_state;

    logic                   r_op;
    logic [PHS_COORD_W-1:0] r_x, r_y;
    logic                   r_sum;
    logic [PHS_KEY_W-1:0]   r_key;
    logic [PHS_KEY_W-1:0]   r_quot;
    logic [BW:0]            r_part;

    logic [PHS_KEY_W-1:0]   w_prod;
    logic [PHS_COORD_W:0]   w_sum;
    logic [2*PHS_KEY_W-1:0] w_qprod;
    logic [BW:0]            w_qb;
    logic [BW-1:0]          w_rem;

    assign w_prod  = r_x * r_y;
    assign w_sum   = {1'b0, r_x} + {1'b0, r_y};

    // quotient estimate by reciprocal is low by at most one, so the
    // partial remainder is below twice the bucket count
    assign w_qprod = (2*PHS_KEY_W)'(r_key) * (2*PHS_KEY_W)'(RECIP);
    assign w_qb    = r_quot[BW:0] * BUCKETS_C;

    always_comb begin
        if (r_part >= BUCKETS_C) begin
            w_rem = BW'(r_part - BUCKETS_C);
        end else begin
            w_rem = BW'(r_part);
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            FR_IDLE: begin
                if (i_valid) begin
                    n_state = FR_HASH;
                end
            end
            FR_HASH: n_state = FR_DIV;
            FR_DIV:  n_state = FR_REM;
            FR_REM:  n_state = FR_PUSH;
            FR_PUSH: begin
                if (!i_full) begin
                    n_state = FR_IDLE;
                end
            end
            default: n_state = FR_IDLE;
        endcase
    end

    always_comb begin
        o_stall = 1'b1;
        o_push  = 1'b0;
        case (r_state)
            FR_IDLE: o_stall = 1'b0;
            FR_PUSH: o_push  = !i_full;
            default: begin
                o_stall = 1'b1;
                o_push  = 1'b0;
            end
        endcase
    end

    assign o_job = {r_op, r_x, r_y, w_rem};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FR_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            FR_IDLE: begin
                if (i_valid) begin
                    r_op  <= i_opcode;
                    r_x   <= i_coord_x;
                    r_y   <= i_coord_y;
                    r_sum <= i_sum_hash;
                end
            end
            FR_HASH: begin
                if (r_sum) begin
                    r_key <= PHS_KEY_W'(w_sum);
                end else begin
                    r_key <= w_prod;
                end
            end
            FR_DIV: begin
                r_quot <= w_qprod[2*PHS_KEY_W-1:PHS_KEY_W];
            end
            FR_REM: begin
                r_part <= r_key[BW:0] - w_qb;
            end
            default: begin
            end
        endcase
    end

endmodule

>>> hw/rtl/phs_queue.sv
module phs_queue import phs_pkg::*; #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty
);

    localparam int AW = (PHS_Q_DEPTH > 1) ? $clog2(PHS_Q_DEPTH) : 1;
    localparam int CW = $clog2(PHS_Q_DEPTH + 1);
    localparam logic [AW-1:0] PTR_LAST = AW'(PHS_Q_DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(PHS_Q_DEPTH);

    logic [W-1:0]  r_mem [PHS_Q_DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;

    assign o_full  = (r_cnt == CNT_FULL);
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PTR_LAST) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PTR_LAST) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

>>> hw/rtl/phs_back.sv
module phs_back import phs_pkg::*; #(
    parameter int BUCKETS = PHS_BUCKETS,
    parameter int NODES   = PHS_NODES
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_empty,
    input  logic [2*PHS_COORD_W+$clog2(BUCKETS):0] i_job,
    output logic                                   o_pop,
    output logic                                   o_clearing,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic                                   o_found,
    output logic                                   o_inserted,
    output logic                                   o_pool_full
);

    localparam int BW = $clog2(BUCKETS);
    localparam int NW = $clog2(NODES);
    localparam int CW = $clog2(NODES + 1);
    localparam int HW = NW + 1;
    localparam int EW = 2*PHS_COORD_W + 1 + NW;
    localparam logic [BW-1:0] CLR_LAST = BW'(BUCKETS - 1);
    localparam logic [CW-1:0] NODES_C  = CW'(NODES);

    t_back_state r_state, n_state;

    // head entry: {valid, node}; node entry: {x, y, next valid, next}
    logic [HW-1:0] head_mem [BUCKETS];
    logic [EW-1:0] node_mem [NODES];
    logic [HW-1:0] r_head_q;
    logic [EW-1:0] r_node_q;

    logic [BW-1:0]          r_clr_addr;
    logic                   r_op;
    logic [PHS_COORD_W-1:0] r_x, r_y;
    logic [BW-1:0]          r_b;
    logic [HW-1:0]          r_head;
    logic                   r_found;
    logic [CW-1:0]          r_used;
    logic                   r_out_valid, r_out_found, r_out_ins, r_out_full;

    logic                   w_job_op;
    logic [PHS_COORD_W-1:0] w_job_x, w_job_y;
    logic [BW-1:0]          w_job_b;
    logic [PHS_COORD_W-1:0] w_nx, w_ny;
    logic                   w_nv;
    logic [NW-1:0]          w_nnext;
    logic                   w_match;
    logic                   w_out_free;
    logic                   w_has_room;

    logic                   head_rd_en, head_wr_en, node_rd_en, commit;
    logic [BW-1:0]          head_rd_addr, head_wr_addr;
    logic [HW-1:0]          head_wr_data;
    logic [NW-1:0]          node_rd_addr;
    logic                   do_ins, do_full;

    assign {w_job_op, w_job_x, w_job_y, w_job_b} = i_job;
    assign {w_nx, w_ny, w_nv, w_nnext}            = r_node_q;
    assign w_match    = (w_nx == r_x) && (w_ny == r_y);
    assign w_out_free = !r_out_valid || !i_stall;
    assign w_has_room = (r_used < NODES_C);
    assign do_ins     = commit && (r_op == OP_INSERT) && !r_found && w_has_room;
    assign do_full    = commit && (r_op == OP_INSERT) && !r_found && !w_has_room;

    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_CLEAR: begin
                if (r_clr_addr == CLR_LAST) begin
                    n_state = BK_IDLE;
                end
            end
            BK_IDLE: begin
                if (!i_empty) begin
                    n_state = BK_HEAD;
                end
            end
            BK_HEAD: n_state = r_head_q[NW] ? BK_NODE : BK_FINISH;
            BK_NODE: begin
                if (w_match || !w_nv) begin
                    n_state = BK_FINISH;
                end
            end
            BK_FINISH: begin
                if (w_out_free) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        o_pop        = 1'b0;
        o_clearing   = 1'b0;
        head_rd_en   = 1'b0;
        head_rd_addr = w_job_b;
        head_wr_en   = 1'b0;
        head_wr_addr = r_b;
        head_wr_data = {1'b1, r_used[NW-1:0]};
        node_rd_en   = 1'b0;
        node_rd_addr = w_nnext;
        commit       = 1'b0;
        case (r_state)
            BK_CLEAR: begin
                o_clearing   = 1'b1;
                head_wr_en   = 1'b1;
                head_wr_addr = r_clr_addr;
                head_wr_data = '0;
            end
            BK_IDLE: begin
                o_pop      = !i_empty;
                head_rd_en = !i_empty;
            end
            BK_HEAD: begin
                node_rd_en   = r_head_q[NW];
                node_rd_addr = r_head_q[NW-1:0];
            end
            BK_NODE: begin
                node_rd_en = !w_match && w_nv;
            end
            BK_FINISH: begin
                commit     = w_out_free;
                head_wr_en = do_ins;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (head_wr_en) begin
            head_mem[head_wr_addr] <= head_wr_data;
        end
        if (head_rd_en) begin
            r_head_q <= head_mem[head_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_ins) begin
            node_mem[r_used[NW-1:0]] <= {r_x, r_y, r_head};
        end
        if (node_rd_en) begin
            r_node_q <= node_mem[node_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_op <= w_job_op;
            r_x  <= w_job_x;
            r_y  <= w_job_y;
            r_b  <= w_job_b;
        end
        if (r_state == BK_HEAD) begin
            r_head  <= r_head_q;
            r_found <= 1'b0;
        end
        if (r_state == BK_NODE && w_match) begin
            r_found <= 1'b1;
        end
        if (commit) begin
            r_out_found <= r_found;
            r_out_ins   <= do_ins;
            r_out_full  <= do_full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_CLEAR;
            r_clr_addr  <= '0;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == BK_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (do_ins) begin
                r_used <= r_used + 1'b1;
            end
            if (commit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid     = r_out_valid;
    assign o_found     = r_out_found;
    assign o_inserted  = r_out_ins;
    assign o_pool_full = r_out_full;

endmodule

>>> hw/rtl/point_hash_set_unit.sv
// Path: the front hashes the item (sum or product, reciprocal modulo, correction, queue
//   push), then the back reads the bucket head, walks the chain and registers the result.
// Overlap: the front hashes the next item while the back walks the current chain, with a
//   2-item queue between; a full queue holds the front and output stalls hold the back.
// Reset: grid size to 1000, pool empty; then a pass over all BUCKETS entries clears the
//   bucket heads, during which o_stall stays high.
module point_hash_set_unit import phs_pkg::*; #(
    parameter int BUCKETS = PHS_BUCKETS,
    parameter int NODES   = PHS_NODES
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [PHS_GRID_W-1:0]  i_cfg_wdata,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic                   i_opcode,
    input  logic [PHS_COORD_W-1:0] i_coord_x,
    input  logic [PHS_COORD_W-1:0] i_coord_y,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic                   o_found,
    output logic                   o_inserted,
    output logic                   o_pool_full
);

    localparam int JW = 2*PHS_COORD_W + $clog2(BUCKETS) + 1;

    logic [PHS_GRID_W-1:0] r_grid_size;
    logic                  w_front_stall, w_clearing;
    logic                  w_push, w_full, w_pop, w_empty;
    logic [JW-1:0]         w_job_in, w_job_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_size <= PHS_GRID_RESET;
        end else if (i_cfg_we) begin
            r_grid_size <= i_cfg_wdata;
        end
    end

    assign o_stall = w_front_stall || w_clearing;

    phs_front #(.BUCKETS(BUCKETS)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_sum_hash (r_grid_size > PHS_SUM_LIMIT),
        .i_valid    (i_valid && !w_clearing),
        .o_stall    (w_front_stall),
        .i_opcode   (i_opcode),
        .i_coord_x  (i_coord_x),
        .i_coord_y  (i_coord_y),
        .o_push     (w_push),
        .o_job      (w_job_in),
        .i_full     (w_full)
    );

    phs_queue #(.W(JW)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_job_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_data  (w_job_out),
        .o_empty (w_empty)
    );

    phs_back #(.BUCKETS(BUCKETS), .NODES(NODES)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (w_empty),
        .i_job       (w_job_out),
        .o_pop       (w_pop),
        .o_clearing  (w_clearing),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_found     (o_found),
        .o_inserted  (o_inserted),
        .o_pool_full (o_pool_full)
    );

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("push into full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_empty)
        else $error("pop from empty queue");

    a_clear_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clearing |-> (o_stall && w_empty))
        else $error("item taken during bucket clear");

    a_result_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_inserted && o_pool_full) && !(o_found && (o_inserted || o_pool_full)))
        else $error("conflicting result flags");

endmodule

>>> tb/sv/tb.sv
module tb;
    import phs_pkg::*;

    typedef struct packed {
        logic                   op;
        logic [PHS_COORD_W-1:0] x;
        logic [PHS_COORD_W-1:0] y;
    } t_probe;

    typedef struct packed {
        logic found;
        logic inserted;
        logic pool_full;
    } t_verdict;

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_cfg_we    = 1'b0;
    logic [PHS_GRID_W-1:0]  i_cfg_wdata = '0;
    logic                   i_valid     = 1'b0;
    logic                   i_opcode    = OP_LOOKUP;
    logic [PHS_COORD_W-1:0] i_coord_x   = '0;
    logic [PHS_COORD_W-1:0] i_coord_y   = '0;
    logic                   i_stall     = 1'b0;
    logic                   o_stall;
    logic                   o_valid;
    logic                   o_found;
    logic                   o_inserted;
    logic                   o_pool_full;

    point_hash_set_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_opcode    (i_opcode),
        .i_coord_x   (i_coord_x),
        .i_coord_y   (i_coord_y),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_found     (o_found),
        .o_inserted  (o_inserted),
        .o_pool_full (o_pool_full)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // shadow copy of the set
    logic [PHS_GRID_W-1:0]  grid_now = PHS_GRID_RESET;
    bit [PHS_COORD_W-1:0]   node_px   [PHS_NODES];
    bit [PHS_COORD_W-1:0]   node_py   [PHS_NODES];
    int unsigned            node_link [PHS_NODES];
    bit                     link_ok   [PHS_NODES];
    int unsigned            head      [PHS_BUCKETS];
    bit                     head_ok   [PHS_BUCKETS];
    int unsigned            nodes_taken = 0;

    t_probe      probe_q[$];
    t_verdict    verdict_q[$];
    logic [31:0] seen[$];
    t_probe      nxt;
    t_verdict    want;
    bit          took = 1'b0;
    int          idle_pct = 0;
    int          stall_pct = 0;
    int          n_queued = 0;
    int          n_accepted = 0;
    int          n_checked = 0;
    int          n_found = 0;
    int          n_ins = 0;
    int          n_full = 0;
    int          n_fail = 0;

    function automatic t_verdict lookup_or_insert(logic op, logic [15:0] x, logic [15:0] y);
        t_verdict    v;
        logic [31:0] key;
        int unsigned b;
        int unsigned n;
        int unsigned steps;
        bit          ok;
        if (grid_now > PHS_SUM_LIMIT) begin
            key = {16'd0, x} + {16'd0, y};
        end else begin
            key = {16'd0, x} * {16'd0, y};
        end
        b     = key % PHS_BUCKETS;
        v     = '0;
        n     = head[b];
        ok    = head_ok[b];
        steps = 0;
        while (ok && !v.found && steps < PHS_NODES) begin
            if (node_px[n] == x && node_py[n] == y) begin
                v.found = 1'b1;
            end else begin
                ok = link_ok[n];
                n  = node_link[n];
                steps++;
            end
        end
        if (op == OP_INSERT && !v.found) begin
            if (nodes_taken >= PHS_NODES) begin
                v.pool_full = 1'b1;
            end else begin
                node_px[nodes_taken]   = x;
                node_py[nodes_taken]   = y;
                node_link[nodes_taken] = head[b];
                link_ok[nodes_taken]   = head_ok[b];
                head[b]                = nodes_taken;
                head_ok[b]             = 1'b1;
                nodes_taken++;
                v.inserted = 1'b1;
            end
        end
        return v;
    endfunction

    // sender
    always @(posedge i_clk) begin
        took = i_valid && !o_stall;
        if (i_rst_n && i_valid && !o_stall) begin
            verdict_q.push_back(lookup_or_insert(i_opcode, i_coord_x, i_coord_y));
            n_accepted++;
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || took) begin
            if (probe_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
                nxt = probe_q.pop_front();
                i_valid   <= 1'b1;
                i_opcode  <= nxt.op;
                i_coord_x <= nxt.x;
                i_coord_y <= nxt.y;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver
    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (verdict_q.size() == 0) begin
                $error("result with no item outstanding");
                n_fail++;
            end else begin
                want = verdict_q.pop_front();
                n_checked++;
                n_found += want.found;
                n_ins   += want.inserted;
                n_full  += want.pool_full;
                if (o_found !== want.found) begin
                    $error("found: expected %0b, got %0b", want.found, o_found);
                    n_fail++;
                end
                if (o_inserted !== want.inserted) begin
                    $error("inserted: expected %0b, got %0b", want.inserted, o_inserted);
                    n_fail++;
                end
                if (o_pool_full !== want.pool_full) begin
                    $error("pool_full: expected %0b, got %0b", want.pool_full, o_pool_full);
                    n_fail++;
                end
            end
        end
    end

    task automatic offer(input logic op, input logic [15:0] x, input logic [15:0] y);
        t_probe p;
        p.op = op;
        p.x  = x;
        p.y  = y;
        probe_q.push_back(p);
        n_queued++;
        if (op == OP_INSERT) begin
            seen.push_back({x, y});
            if (seen.size() > 64) begin
                void'(seen.pop_front());
            end
        end
    endtask

    function automatic logic [15:0] corner_value();
        case ($urandom_range(5))
            0: return 16'd0;
            1: return 16'd1;
            2: return 16'd65535;
            3: return 16'd1023;
            4: return 16'd1024;
            default: return 16'd32768;
        endcase
    endfunction

    task automatic offer_random();
        logic        op;
        logic [15:0] x;
        logic [15:0] y;
        logic [31:0] h;
        int          sel;
        sel = $urandom_range(99);
        op  = ($urandom_range(1) == 1) ? OP_INSERT : OP_LOOKUP;
        if (sel < 40 && seen.size() > 0) begin
            h = seen[$urandom_range(seen.size() - 1)];
            x = h[31:16];
            y = h[15:0];
        end else if (sel < 55) begin
            x = corner_value();
            y = corner_value();
        end else if (sel < 62) begin
            // product lands in bucket zero
            x = {6'($urandom), 10'd0};
            y = 16'($urandom);
        end else if (sel < 70) begin
            // sum lands in bucket zero
            h = {22'd0, 10'($urandom)};
            x = {6'($urandom), h[9:0]};
            y = {6'($urandom), 10'(11'd1024 - h[10:0])};
        end else begin
            x = 16'($urandom);
            y = 16'($urandom);
        end
        offer(op, x, y);
        if (op == OP_INSERT && $urandom_range(9) < 3) begin
            offer(OP_LOOKUP, x, y);
        end
    endtask

    task automatic drain();
        while (n_accepted != n_queued || verdict_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_grid(input logic [15:0] v);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        grid_now = v;
    endtask

    task automatic set_pace(input int send_idle, input int rx_stall);
        idle_pct  = send_idle;
        stall_pct = rx_stall;
    endtask

    task automatic run_phase(input logic [15:0] grid, input int send_idle, input int rx_stall,
                             input int count);
        drain();
        write_grid(grid);
        set_pace(send_idle, rx_stall);
        repeat (count) offer_random();
    endtask

    initial begin
        #60000000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // product hash at the reset grid size
        offer(OP_LOOKUP, 16'd0, 16'd0);
        offer(OP_INSERT, 16'd0, 16'd0);
        offer(OP_INSERT, 16'd0, 16'd0);
        offer(OP_LOOKUP, 16'd0, 16'd0);
        offer(OP_INSERT, 16'd65535, 16'd65535);
        offer(OP_LOOKUP, 16'd65535, 16'd65535);
        offer(OP_INSERT, 16'd65535, 16'd0);
        offer(OP_INSERT, 16'd0, 16'd65535);
        offer(OP_INSERT, 16'd1024, 16'd1);
        offer(OP_LOOKUP, 16'd1, 16'd1024);
        offer(OP_INSERT, 16'd1, 16'd1024);
        offer(OP_LOOKUP, 16'd0, 16'd0);
        offer(OP_INSERT, 16'd65534, 16'd65533);
        offer(OP_LOOKUP, 16'd65533, 16'd65534);
        offer(OP_INSERT, 16'd32768, 16'd2);
        offer(OP_LOOKUP, 16'd12345, 16'd54321);
        offer(OP_INSERT, 16'd65535, 16'd65535);

        // sum hash: most points stored under the product now map to other buckets
        drain();
        write_grid(16'd40001);
        offer(OP_LOOKUP, 16'd65535, 16'd65535);
        offer(OP_INSERT, 16'd65535, 16'd65535);
        offer(OP_LOOKUP, 16'd0, 16'd0);
        offer(OP_INSERT, 16'd1, 16'd1023);
        offer(OP_LOOKUP, 16'd1023, 16'd1);

        run_phase(16'd1, 72, 0, 110);
        run_phase(16'd40000, 0, 72, 55);
        drain();
        repeat (55) offer_random();
        run_phase(16'd40001, 19, 19, 110);
        run_phase(16'd65535, 0, 0, 110);
        run_phase(16'd1000, 0, 72, 60);
        run_phase(16'd40001, 72, 0, 60);
        run_phase(16'd1, 19, 19, 60);

        drain();
        repeat (60) @(posedge i_clk);
        if (verdict_q.size() != 0) begin
            $error("%0d results never arrived", verdict_q.size());
            n_fail++;
        end
        $display("%0d items checked: %0d found, %0d inserted, %0d dropped on a full pool",
                 n_checked, n_found, n_ins, n_full);
        $display("product and sum hashes, grid sizes 1 to 65535, with and without back-pressure");
        if (n_fail == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
